// File: src/biq_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package biq_pkg;

	// Field widths
	localparam int SAMPLE_W   = 24;
	localparam int FF_COEF_W  = 16;
	localparam int FB_COEF_W  = 18;
	localparam int GAIN_W     = 24;
	localparam int HIST_W     = 40;
	localparam int HIST_FRAC  = 8;
	localparam int OUT_W      = 32;

	// Both the gain product and the feedback sum drop 16 fraction bits
	localparam int RND_SHIFT  = 16;

	// Serial MAC sizing: widest product is S (42b) times gain (24b)
	localparam int ACC_W      = 68;
	localparam int RES_W      = ACC_W - RND_SHIFT;
	localparam int MPL_W      = 24;
	localparam int CNT_W      = 5;

	localparam logic signed [ACC_W-1:0] RND_INIT = ACC_W'(1) << (RND_SHIFT - 1);

	localparam logic signed [HIST_W-1:0] HIST_MAX = {1'b0, {(HIST_W-1){1'b1}}};
	localparam logic signed [HIST_W-1:0] HIST_MIN = {1'b1, {(HIST_W-1){1'b0}}};
	localparam logic signed [OUT_W-1:0]  OUT_MAX  = {1'b0, {(OUT_W-1){1'b1}}};
	localparam logic signed [OUT_W-1:0]  OUT_MIN  = {1'b1, {(OUT_W-1){1'b0}}};

	// Configuration port
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 24;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_FF_COEF_0 = 3'd0,
		CFG_FF_COEF_1 = 3'd1,
		CFG_FF_COEF_2 = 3'd2,
		CFG_FB_COEF_1 = 3'd3,
		CFG_FB_COEF_2 = 3'd4,
		CFG_FF_GAIN   = 3'd5
	} cfg_reg_t;

	// Register reset values
	localparam logic signed [FF_COEF_W-1:0] FF_COEF_0_RST = 16'sd1;
	localparam logic signed [FF_COEF_W-1:0] FF_COEF_1_RST = 16'sd10;
	localparam logic signed [FF_COEF_W-1:0] FF_COEF_2_RST = 16'sd25;
	localparam logic signed [FB_COEF_W-1:0] FB_COEF_1_RST = -18'sd84766;
	localparam logic signed [FB_COEF_W-1:0] FB_COEF_2_RST = 18'sd32113;
	localparam logic [GAIN_W-1:0]           FF_GAIN_RST   = 24'd91771;

	// Sequencer
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_LOAD,
		ST_RUN,
		ST_DIFF,
		ST_DONE
	} seq_state_t;

	typedef enum logic [1:0] {
		PH_FF,
		PH_GAIN,
		PH_FB
	} phase_t;

	// Sequencer to serial MAC
	typedef struct packed {
		logic start;
		logic acc_clr;
		logic rnd;
		logic step;
		logic sub;
	} mac_cmd_t;

	// Sequencer to output stage
	typedef struct packed {
		logic                     load;
		logic                     sat;
		logic signed [HIST_W-1:0] y;
	} out_req_t;

endpackage

`default_nettype wire

// File: src/biq_mac.sv
`timescale 1ns / 1ps
`default_nettype none

// Bit-serial shift-add multiply-accumulate: one multiplier bit per cycle while cmd.step is set
module biq_mac import biq_pkg::*; (
	input  wire logic                    clk,
	input  wire mac_cmd_t                cmd,
	input  wire logic signed [ACC_W-1:0] mcand,
	input  wire logic [MPL_W-1:0]        mplier,
	output logic signed [ACC_W-1:0]      acc
);

	logic signed [ACC_W-1:0] mcand_q;
	logic [MPL_W-1:0]        mplier_q;
	logic signed [ACC_W-1:0] acc_q;
	logic signed [ACC_W-1:0] acc_d;

	// Add or subtract the shifted multiplicand when the current bit is set
	always_comb begin
		acc_d = acc_q;
		if (mplier_q[0]) begin
			if (cmd.sub) begin
				acc_d = acc_q - mcand_q;
			end else begin
				acc_d = acc_q + mcand_q;
			end
		end
	end

	// Operand shift registers and accumulator
	always_ff @(posedge clk) begin
		if (cmd.start) begin
			mcand_q  <= mcand;
			mplier_q <= mplier;
			if (cmd.acc_clr) begin
				acc_q <= cmd.rnd ? RND_INIT : '0;
			end
		end else if (cmd.step) begin
			acc_q    <= acc_d;
			mcand_q  <= mcand_q <<< 1;
			mplier_q <= mplier_q >> 1;
		end
	end

	assign acc = acc_q;

endmodule

`default_nettype wire

// File: src/biq_seq.sv
`timescale 1ns / 1ps
`default_nettype none

// Sequencer: filter history, operand selection and the final difference
module biq_seq import biq_pkg::*; (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        in_valid,
	output logic                             in_ready,
	input  wire logic signed [SAMPLE_W-1:0]  sample,
	input  wire logic                        first_sample,
	input  wire logic signed [FF_COEF_W-1:0] ff_coef_0,
	input  wire logic signed [FF_COEF_W-1:0] ff_coef_1,
	input  wire logic signed [FF_COEF_W-1:0] ff_coef_2,
	input  wire logic signed [FB_COEF_W-1:0] fb_coef_1,
	input  wire logic signed [FB_COEF_W-1:0] fb_coef_2,
	input  wire logic [GAIN_W-1:0]           ff_gain,
	output mac_cmd_t                         mac_cmd,
	output logic signed [ACC_W-1:0]          mcand,
	output logic [MPL_W-1:0]                 mplier,
	input  wire logic signed [ACC_W-1:0]     acc,
	input  wire logic                        out_free,
	output out_req_t                         out_req
);

	seq_state_t state_q, state_d;
	phase_t     phase_q, phase_d;
	logic [1:0]       term_q, term_d;
	logic [CNT_W-1:0] cnt_q, cnt_d;

	logic signed [SAMPLE_W-1:0] x_q, x1_q, x2_q;
	logic signed [HIST_W-1:0]   y1_q, y2_q;
	logic signed [RES_W-1:0]    ff_q;
	logic                       sat_q;

	logic [CNT_W-1:0]         run_len;
	logic                     last_bit;
	logic                     last_term;
	logic                     accept;
	logic                     diff_en;
	logic                     ff_cap;
	logic signed [RES_W-1:0]  fb_res;
	logic signed [RES_W:0]    diff;
	logic [RES_W-HIST_W+1:0]  diff_hi;
	logic                     hist_ovf;
	logic signed [HIST_W-1:0] y_new;

	// Bits per product and terms per phase
	always_comb begin
		run_len   = CNT_W'(FF_COEF_W);
		last_term = 1'b0;
		unique case (phase_q)
			PH_FF: begin
				run_len   = CNT_W'(FF_COEF_W);
				last_term = (term_q == 2'd2);
			end
			PH_GAIN: begin
				run_len   = CNT_W'(GAIN_W);
				last_term = 1'b1;
			end
			PH_FB: begin
				run_len   = CNT_W'(FB_COEF_W);
				last_term = (term_q == 2'd1);
			end
			default: begin
				run_len   = CNT_W'(FF_COEF_W);
				last_term = 1'b1;
			end
		endcase
	end

	assign last_bit = (cnt_q == run_len - 1'b1);

	// Operand select for the product being loaded
	always_comb begin
		mcand  = '0;
		mplier = '0;
		unique case (phase_q)
			PH_FF: begin
				unique case (term_q)
					2'd0: begin
						mcand  = ACC_W'(x_q);
						mplier = MPL_W'($unsigned(ff_coef_0));
					end
					2'd1: begin
						mcand  = ACC_W'(x1_q);
						mplier = MPL_W'($unsigned(ff_coef_1));
					end
					default: begin
						mcand  = ACC_W'(x2_q);
						mplier = MPL_W'($unsigned(ff_coef_2));
					end
				endcase
			end
			PH_GAIN: begin
				// feedforward sum S sits in the accumulator
				mcand  = acc;
				mplier = ff_gain;
			end
			default: begin
				if (term_q == 2'd0) begin
					mcand  = ACC_W'(y1_q);
					mplier = MPL_W'($unsigned(fb_coef_1));
				end else begin
					mcand  = ACC_W'(y2_q);
					mplier = MPL_W'($unsigned(fb_coef_2));
				end
			end
		endcase
	end

	// New output history value: ff - fb, clipped to the history range
	always_comb begin
		fb_res   = RES_W'(acc >>> RND_SHIFT);
		diff     = {ff_q[RES_W-1], ff_q} - {fb_res[RES_W-1], fb_res};
		diff_hi  = diff[RES_W:HIST_W-1];
		hist_ovf = !((&diff_hi) || (~|diff_hi));
		if (hist_ovf) begin
			y_new = diff[RES_W] ? HIST_MIN : HIST_MAX;
		end else begin
			y_new = diff[HIST_W-1:0];
		end
	end

	// Next state and control
	always_comb begin
		state_d     = state_q;
		phase_d     = phase_q;
		term_d      = term_q;
		cnt_d       = cnt_q;
		in_ready    = 1'b0;
		accept      = 1'b0;
		diff_en     = 1'b0;
		ff_cap      = 1'b0;
		mac_cmd     = '0;
		out_req.load = 1'b0;
		out_req.sat  = sat_q;
		out_req.y    = y1_q;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					accept  = 1'b1;
					state_d = ST_LOAD;
					phase_d = PH_FF;
					term_d  = '0;
				end
			end
			ST_LOAD: begin
				mac_cmd.start   = 1'b1;
				mac_cmd.acc_clr = (term_q == 2'd0);
				mac_cmd.rnd     = (phase_q != PH_FF);
				ff_cap          = (phase_q == PH_FB) && (term_q == 2'd0);
				cnt_d           = '0;
				state_d         = ST_RUN;
			end
			ST_RUN: begin
				mac_cmd.step = 1'b1;
				// sign bit of a signed coefficient carries negative weight
				mac_cmd.sub  = last_bit && (phase_q != PH_GAIN);
				cnt_d        = cnt_q + 1'b1;
				if (last_bit) begin
					state_d = ST_LOAD;
					if (last_term) begin
						term_d = '0;
						unique case (phase_q)
							PH_FF:   phase_d = PH_GAIN;
							PH_GAIN: phase_d = PH_FB;
							default: state_d = ST_DIFF;
						endcase
					end else begin
						term_d = term_q + 1'b1;
					end
				end
			end
			ST_DIFF: begin
				diff_en = 1'b1;
				state_d = ST_DONE;
			end
			ST_DONE: begin
				if (out_free) begin
					out_req.load = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			phase_q <= PH_FF;
			term_q  <= '0;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			phase_q <= phase_d;
			term_q  <= term_d;
			cnt_q   <= cnt_d;
		end
	end

	// Filter history: cleared by reset and by a first sample
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x1_q <= '0;
			x2_q <= '0;
			y1_q <= '0;
			y2_q <= '0;
		end else if (accept && first_sample) begin
			x1_q <= '0;
			x2_q <= '0;
			y1_q <= '0;
			y2_q <= '0;
		end else if (diff_en) begin
			x2_q <= x1_q;
			x1_q <= x_q;
			y2_q <= y1_q;
			y1_q <= y_new;
		end
	end

	// Current sample, feedforward result, history clip flag
	always_ff @(posedge clk) begin
		if (accept) begin
			x_q <= sample;
		end
		if (ff_cap) begin
			ff_q <= RES_W'(acc >>> RND_SHIFT);
		end
		if (diff_en) begin
			sat_q <= hist_ovf;
		end
	end

endmodule

`default_nettype wire

// File: src/biq_out.sv
`timescale 1ns / 1ps
`default_nettype none

// Output stage: round history value to integer, clip, hold for transfer
module biq_out import biq_pkg::*; (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire out_req_t     req,
	output logic              free,
	output logic              out_valid,
	input  wire logic         out_ready,
	output logic [OUT_W-1:0]  filtered,
	output logic              saturated
);

	localparam int RND_W = HIST_W + 1;
	localparam int INT_W = RND_W - HIST_FRAC;

	logic                     valid_q;
	logic [OUT_W-1:0]         data_q;
	logic                     sat_q;
	logic signed [RND_W-1:0]  rnd_sum;
	logic signed [INT_W-1:0]  int_val;
	logic [INT_W-OUT_W:0]     int_hi;
	logic                     out_ovf;
	logic [OUT_W-1:0]         out_val;

	// Round half up, then clip to the output range
	always_comb begin
		rnd_sum = {req.y[HIST_W-1], req.y} + (RND_W'(1) << (HIST_FRAC - 1));
		int_val = rnd_sum[RND_W-1:HIST_FRAC];
		int_hi  = int_val[INT_W-1:OUT_W-1];
		out_ovf = !((&int_hi) || (~|int_hi));
		if (out_ovf) begin
			out_val = int_val[INT_W-1] ? OUT_MIN : OUT_MAX;
		end else begin
			out_val = int_val[OUT_W-1:0];
		end
	end

	assign free = !valid_q || out_ready;

	// Output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (req.load) begin
			valid_q <= 1'b1;
		end else if (out_ready) begin
			valid_q <= 1'b0;
		end
	end

	// Output payload
	always_ff @(posedge clk) begin
		if (req.load) begin
			data_q <= out_val;
			sat_q  <= req.sat || out_ovf;
		end
	end

	assign out_valid = valid_q;
	assign filtered  = data_q;
	assign saturated = sat_q;

endmodule

`default_nettype wire

// File: src/biquad_iir_sample_filter_core.sv
// Samples are processed one at a time: a new input is accepted only in the idle state,
// after the previous result has been handed to the output register. The bit-serial MAC
// takes one multiplier bit a cycle over six products (3 x 16 + 24 + 2 x 18 bits) plus a load
// step per product; a result not yet taken holds the sequencer at its last step.
// Reset (arst_n low) restores default coefficients, zeroes the filter history and
// empties the output register.
`timescale 1ns / 1ps
`default_nettype none

module biquad_iir_sample_filter_core import biq_pkg::*; (
	input  wire logic                  clk,
	input  wire logic                  arst_n,

	input  wire logic                  s_axis_tvalid,
	output logic                       s_axis_tready,
	input  wire logic [SAMPLE_W-1:0]   s_axis_tdata,   // [23:0] sample
	input  wire logic                  s_axis_tuser,   // [0] first_sample

	output logic                       m_axis_tvalid,
	input  wire logic                  m_axis_tready,
	output logic [OUT_W-1:0]           m_axis_tdata,   // [31:0] filtered
	output logic                       m_axis_tuser,   // [0] saturated

	input  wire logic                  cfg_valid,
	output logic                       cfg_ready,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data
);

	logic signed [FF_COEF_W-1:0] ff_coef_0_q, ff_coef_1_q, ff_coef_2_q;
	logic signed [FB_COEF_W-1:0] fb_coef_1_q, fb_coef_2_q;
	logic [GAIN_W-1:0]           ff_gain_q;

	mac_cmd_t                mac_cmd;
	logic signed [ACC_W-1:0] mcand;
	logic [MPL_W-1:0]        mplier;
	logic signed [ACC_W-1:0] acc;
	out_req_t                out_req;
	logic                    out_free;

	assign cfg_ready = 1'b1;

	// Coefficient registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ff_coef_0_q <= FF_COEF_0_RST;
			ff_coef_1_q <= FF_COEF_1_RST;
			ff_coef_2_q <= FF_COEF_2_RST;
			fb_coef_1_q <= FB_COEF_1_RST;
			fb_coef_2_q <= FB_COEF_2_RST;
			ff_gain_q   <= FF_GAIN_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_reg_t'(cfg_index))
				CFG_FF_COEF_0: ff_coef_0_q <= cfg_data[FF_COEF_W-1:0];
				CFG_FF_COEF_1: ff_coef_1_q <= cfg_data[FF_COEF_W-1:0];
				CFG_FF_COEF_2: ff_coef_2_q <= cfg_data[FF_COEF_W-1:0];
				CFG_FB_COEF_1: fb_coef_1_q <= cfg_data[FB_COEF_W-1:0];
				CFG_FB_COEF_2: fb_coef_2_q <= cfg_data[FB_COEF_W-1:0];
				CFG_FF_GAIN:   ff_gain_q   <= cfg_data[GAIN_W-1:0];
				default: ;
			endcase
		end
	end

	biq_seq u_seq (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (s_axis_tvalid),
		.in_ready     (s_axis_tready),
		.sample       (s_axis_tdata),
		.first_sample (s_axis_tuser),
		.ff_coef_0    (ff_coef_0_q),
		.ff_coef_1    (ff_coef_1_q),
		.ff_coef_2    (ff_coef_2_q),
		.fb_coef_1    (fb_coef_1_q),
		.fb_coef_2    (fb_coef_2_q),
		.ff_gain      (ff_gain_q),
		.mac_cmd      (mac_cmd),
		.mcand        (mcand),
		.mplier       (mplier),
		.acc          (acc),
		.out_free     (out_free),
		.out_req      (out_req)
	);

	biq_mac u_mac (
		.clk    (clk),
		.cmd    (mac_cmd),
		.mcand  (mcand),
		.mplier (mplier),
		.acc    (acc)
	);

	biq_out u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (out_req),
		.free      (out_free),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.filtered  (m_axis_tdata),
		.saturated (m_axis_tuser)
	);

endmodule

`default_nettype wire

// File: verif/biquad_iir_sample_filter_core_test.sv
`timescale 1ns / 1ps

module biquad_iir_sample_filter_core_test;
	import biq_pkg::*;

	localparam int QUIET_LIMIT = 5000;
	localparam int HOLD_CYCLES = 800;
	localparam int SETTLE_CYCLES = 150;

	localparam logic [SAMPLE_W-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_W-1){1'b1}}};
	localparam logic [SAMPLE_W-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_W-1){1'b0}}};

	// Indexes with no register behind them
	localparam logic [CFG_IDX_W-1:0] CFG_UNMAPPED_A = 3'd6;
	localparam logic [CFG_IDX_W-1:0] CFG_UNMAPPED_B = 3'd7;

	typedef struct packed {
		logic [OUT_W-1:0] filtered;
		logic             saturated;
	} filter_out_t;

	// Tracks coefficients and filter history, predicts each output
	class biquad_scoreboard;
		logic signed [FF_COEF_W-1:0] b0, b1, b2;
		logic signed [FB_COEF_W-1:0] a1, a2;
		logic [GAIN_W-1:0]           gain;
		logic signed [SAMPLE_W-1:0]  x1, x2;
		logic signed [HIST_W-1:0]    y1, y2;
		filter_out_t                 expected_outputs[$];
		int unsigned samples, runs, clipped, writes, checked, mismatches;

		function new();
			b0 = FF_COEF_0_RST;
			b1 = FF_COEF_1_RST;
			b2 = FF_COEF_2_RST;
			a1 = FB_COEF_1_RST;
			a2 = FB_COEF_2_RST;
			gain = FF_GAIN_RST;
			x1 = '0;
			x2 = '0;
			y1 = '0;
			y2 = '0;
			samples = 0;
			runs = 0;
			clipped = 0;
			writes = 0;
			checked = 0;
			mismatches = 0;
		endfunction

		function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
			case (idx)
				CFG_FF_COEF_0: b0 = data[FF_COEF_W-1:0];
				CFG_FF_COEF_1: b1 = data[FF_COEF_W-1:0];
				CFG_FF_COEF_2: b2 = data[FF_COEF_W-1:0];
				CFG_FB_COEF_1: a1 = data[FB_COEF_W-1:0];
				CFG_FB_COEF_2: a2 = data[FB_COEF_W-1:0];
				CFG_FF_GAIN:   gain = data[GAIN_W-1:0];
				default: ;
			endcase
			writes++;
		endfunction

		function void accept_sample(logic [SAMPLE_W-1:0] sample, logic first);
			logic signed [95:0] x, k0, k1, k2, k3, k4, kg, d1, d2, h1, h2;
			logic signed [95:0] ffsum, ffv, fbv, yv, ov;
			logic sat;
			filter_out_t res;
			if (first) begin
				x1 = '0;
				x2 = '0;
				y1 = '0;
				y2 = '0;
				runs++;
			end
			x = $signed(sample);
			k0 = b0;
			k1 = b1;
			k2 = b2;
			k3 = a1;
			k4 = a2;
			kg = {72'd0, gain};
			d1 = x1;
			d2 = x2;
			h1 = y1;
			h2 = y2;
			// feedforward sum scaled by the gain, feedback on Q.8 history; both round half up
			ffsum = k0 * x + k1 * d1 + k2 * d2;
			ffv = (ffsum * kg + 96'sd32768) >>> RND_SHIFT;
			fbv = (k3 * h1 + k4 * h2 + 96'sd32768) >>> RND_SHIFT;
			yv = ffv - fbv;
			sat = 1'b0;
			if (yv > HIST_MAX) begin
				yv = HIST_MAX;
				sat = 1'b1;
			end
			if (yv < HIST_MIN) begin
				yv = HIST_MIN;
				sat = 1'b1;
			end
			x2 = x1;
			x1 = sample;
			y2 = y1;
			y1 = yv[HIST_W-1:0];
			// drop the history fraction with rounding, then clip to 32 bits
			ov = (yv + 96'sd128) >>> HIST_FRAC;
			if (ov > OUT_MAX) begin
				ov = OUT_MAX;
				sat = 1'b1;
			end
			if (ov < OUT_MIN) begin
				ov = OUT_MIN;
				sat = 1'b1;
			end
			res.filtered = ov[OUT_W-1:0];
			res.saturated = sat;
			if (sat)
				clipped++;
			samples++;
			expected_outputs.push_back(res);
		endfunction

		function void check_output(logic [OUT_W-1:0] filtered, logic saturated);
			filter_out_t want;
			if (expected_outputs.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected output: filtered %0d saturated %0b",
						$signed(filtered), saturated);
				return;
			end
			want = expected_outputs.pop_front();
			checked++;
			if (filtered !== want.filtered || saturated !== want.saturated) begin
				mismatches++;
				if (mismatches <= 10)
					$display("output %0d: filtered exp %0d got %0d, saturated exp %0b got %0b",
						checked, $signed(want.filtered), $signed(filtered),
						want.saturated, saturated);
			end
		endfunction

		function int pending();
			return expected_outputs.size();
		endfunction
	endclass

	logic                  clk;
	logic                  arst_n;
	logic                  s_axis_tvalid;
	logic                  s_axis_tready;
	logic [SAMPLE_W-1:0]   s_axis_tdata;   // [23:0] sample
	logic                  s_axis_tuser;   // [0] first_sample
	logic                  m_axis_tvalid;
	logic                  m_axis_tready;
	logic [OUT_W-1:0]      m_axis_tdata;   // [31:0] filtered
	logic                  m_axis_tuser;   // [0] saturated
	logic                  cfg_valid;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	biquad_scoreboard sb;
	bit steady;
	bit hold_out_req;
	int quiet_cycles;

	biquad_iir_sample_filter_core dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Output side: random backpressure, plus one long hold when asked
	initial begin
		m_axis_tready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_out_req) begin
				hold_out_req = 1'b0;
				m_axis_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end
			m_axis_tready <= steady || ($urandom_range(99) >= 24);
		end
	end

	// Transfer monitor and watchdog
	always @(posedge clk) begin
		if (arst_n) begin
			if (s_axis_tvalid && s_axis_tready)
				sb.accept_sample(s_axis_tdata, s_axis_tuser);
			if (m_axis_tvalid && m_axis_tready)
				sb.check_output(m_axis_tdata, m_axis_tuser);
			if (cfg_valid && cfg_ready)
				sb.write_reg(cfg_index, cfg_data);
			if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
					(cfg_valid && cfg_ready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("watchdog: no transfer for %0d cycles, %0d outputs outstanding",
					quiet_cycles, sb.pending());
				$display("end of test: mismatches");
				$finish;
			end
		end
	end

	task automatic send_sample(input logic [SAMPLE_W-1:0] sample, input logic first);
		int gap;
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= sample;
		s_axis_tuser <= first;
		do @(posedge clk); while (!s_axis_tready);
		if (!steady && $urandom_range(99) < 24) begin
			s_axis_tvalid <= 1'b0;
			gap = ($urandom_range(7) == 0) ? $urandom_range(200, 1) : $urandom_range(3, 1);
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic write_one(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
	endtask

	// Filter must be idle: every output already taken
	task automatic drain();
		s_axis_tvalid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic apply_settings(input logic [CFG_DATA_W-1:0] c0, c1, c2, c3, c4, c5);
		write_one(CFG_FF_COEF_0, c0);
		write_one(CFG_FF_COEF_1, c1);
		write_one(CFG_FF_COEF_2, c2);
		write_one(CFG_FB_COEF_1, c3);
		write_one(CFG_FB_COEF_2, c4);
		write_one(CFG_FF_GAIN, c5);
		write_one(CFG_UNMAPPED_A, CFG_DATA_W'($urandom));
		write_one(CFG_UNMAPPED_B, CFG_DATA_W'($urandom));
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	// Runs that mostly open with a history clear, with stray clears mixed in
	task automatic random_runs(input int count);
		int left, run_len, pos;
		logic first;
		logic [SAMPLE_W-1:0] smp;
		left = count;
		while (left > 0) begin
			run_len = $urandom_range(40, 1);
			for (pos = 0; pos < run_len && left > 0; pos++) begin
				first = (pos == 0) ? ($urandom_range(5) != 0) : ($urandom_range(19) == 0);
				case ($urandom_range(9))
					0: smp = SAMPLE_MAX;
					1: smp = SAMPLE_MIN;
					2, 3: smp = SAMPLE_W'($urandom_range(512)) - SAMPLE_W'(256);
					default: smp = SAMPLE_W'($urandom);
				endcase
				send_sample(smp, first);
				left--;
			end
		end
	endtask

	initial begin
		sb = new();
		arst_n = 1'b0;
		quiet_cycles = 0;
		steady = 1'b0;
		hold_out_req = 1'b0;
		s_axis_tvalid <= 1'b0;
		s_axis_tdata <= '0;
		s_axis_tuser <= 1'b0;
		cfg_valid <= 1'b0;
		cfg_index <= CFG_FF_COEF_0;
		cfg_data <= '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset coefficients: step responses at both sample extremes
		send_sample('0, 1'b1);
		repeat (4) send_sample(SAMPLE_MAX, 1'b0);
		send_sample(SAMPLE_MIN, 1'b1);
		repeat (3) send_sample(SAMPLE_MIN, 1'b0);
		send_sample(SAMPLE_W'(1), 1'b1);
		send_sample(SAMPLE_W'(-1), 1'b0);
		send_sample('0, 1'b0);
		send_sample(SAMPLE_MAX, 1'b1);
		drain();

		// Largest coefficients and gain: history and output clip both ways
		apply_settings(CFG_DATA_W'(32767), CFG_DATA_W'(32767), CFG_DATA_W'(32767),
			CFG_DATA_W'(-131072), CFG_DATA_W'(131071), {CFG_DATA_W{1'b1}});
		send_sample(SAMPLE_MAX, 1'b1);
		repeat (2) send_sample(SAMPLE_MAX, 1'b0);
		send_sample(SAMPLE_MIN, 1'b1);
		repeat (2) send_sample(SAMPLE_MIN, 1'b0);
		drain();

		// Most negative feedforward coefficients and a2, largest a1, with zero gain
		apply_settings(CFG_DATA_W'(-32768), CFG_DATA_W'(-32768), CFG_DATA_W'(-32768),
			CFG_DATA_W'(131071), CFG_DATA_W'(-131072), '0);
		send_sample(SAMPLE_MAX, 1'b1);
		send_sample(SAMPLE_MIN, 1'b0);
		send_sample(SAMPLE_MAX, 1'b0);
		drain();

		// Random phases: even ones near the stable reset filter, odd ones anything goes
		for (int p = 0; p < 6; p++) begin
			if (p % 2 == 0)
				apply_settings(CFG_DATA_W'(int'($urandom_range(200)) - 100),
					CFG_DATA_W'(int'($urandom_range(200)) - 100),
					CFG_DATA_W'(int'($urandom_range(200)) - 100),
					CFG_DATA_W'(-84766 + int'($urandom_range(4000)) - 2000),
					CFG_DATA_W'(32113 + int'($urandom_range(4000)) - 2000),
					CFG_DATA_W'($urandom_range(1 << 20)));
			else
				apply_settings(CFG_DATA_W'($urandom), CFG_DATA_W'($urandom),
					CFG_DATA_W'($urandom), CFG_DATA_W'($urandom),
					CFG_DATA_W'($urandom), CFG_DATA_W'($urandom));
			steady = (p == 2);
			if (p == 4)
				hold_out_req = 1'b1;
			random_runs(80);
			drain();
			steady = 1'b0;
		end

		s_axis_tvalid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);

		$display("covered %0d samples in %0d cleared runs, %0d of them clipped",
			sb.samples, sb.runs, sb.clipped);
		$display("%0d register writes over 9 coefficient sets, %0d outputs compared",
			sb.writes, sb.checked);
		if (sb.mismatches == 0 && sb.pending() == 0) begin
			$display("end of test: clean");
		end else begin
			$display("%0d mismatches", sb.mismatches);
			$display("end of test: mismatches");
		end
		$finish;
	end

endmodule
